### rtl/gap_buffer_line_editor_top_macros.svh
// assertion macros for the gap buffer line editor
// used by the top level; no other dependencies
`ifndef GAP_BUFFER_LINE_EDITOR_TOP_MACROS_SVH
`define GAP_BUFFER_LINE_EDITOR_TOP_MACROS_SVH

// property must hold at every clock edge outside reset
`define GBLE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define GBLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### rtl/gble_pkg.sv
// shared constants, op codes and controller/datapath bundles
// for the gap buffer line editor; no dependencies
`default_nettype none

package gble_pkg;

  // line storage geometry
  localparam int MAX_CHARS = 64;
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  localparam int LEN_W     = 7;
  localparam int TOT_W     = LEN_W + 1;

  localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(MAX_CHARS);
  localparam logic [6:0]       MAXLEN_RESET  = 7'd64;

  // printable character range
  localparam logic [7:0] CHAR_MIN = 8'h20;
  localparam logic [7:0] CHAR_MAX = 8'h7E;

  // edit op codes
  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_LEFT    = 3'd1;
  localparam logic [2:0] OP_RIGHT   = 3'd2;
  localparam logic [2:0] OP_BKSP    = 3'd3;
  localparam logic [2:0] OP_DELETE  = 3'd4;
  localparam logic [2:0] OP_SUBMIT  = 3'd5;

  // configuration register index
  localparam logic REG_LINE_LIMIT = 1'b0;

  // commands from controller to datapath
  typedef struct packed {
    logic take_item;
    logic ins_wr;
    logic mvl_rd;
    logic mvr_rd;
    logic mvl_wr;
    logic mvr_wr;
    logic bksp;
    logic delf;
    logic st_load;
    logic st_applied;
    logic sub_start;
    logic sub_rd;
    logic sub_load;
    logic clear;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0]       op;
    logic             ins_ok;
    logic             left_nz;
    logic             right_nz;
    logic             left_room;
    logic             right_room;
    logic             sub_ok;
    logic             out_free;
    logic             idx_last;
    logic [TOT_W-1:0] total;
  } sts_t;

endpackage

`default_nettype wire

### rtl/gble_ctrl.sv
// controller state machine of the gap buffer line editor
// depends on gble_pkg for op codes and the command/status bundles
`default_nettype none

module gble_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  gble_pkg::sts_t sts_i,
  output gble_pkg::cmd_t cmd_o
);
  import gble_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_MOVE = 3'd2;
  localparam logic [2:0] ST_SRD  = 3'd3;
  localparam logic [2:0] ST_SLD  = 3'd4;

  logic [2:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.out_free) begin
              cmd_o.ins_wr     = sts_i.ins_ok;
              cmd_o.st_load    = 1'b1;
              cmd_o.st_applied = sts_i.ins_ok;
              state_d          = ST_IDLE;
            end
          end
          OP_LEFT: begin
            if (sts_i.left_nz && sts_i.right_room) begin
              cmd_o.mvl_rd = 1'b1;
              state_d      = ST_MOVE;
            end else if (sts_i.out_free) begin
              cmd_o.st_load = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          OP_RIGHT: begin
            if (sts_i.right_nz && sts_i.left_room) begin
              cmd_o.mvr_rd = 1'b1;
              state_d      = ST_MOVE;
            end else if (sts_i.out_free) begin
              cmd_o.st_load = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          OP_BKSP: begin
            if (sts_i.out_free) begin
              cmd_o.bksp       = sts_i.left_nz;
              cmd_o.st_load    = 1'b1;
              cmd_o.st_applied = sts_i.left_nz;
              state_d          = ST_IDLE;
            end
          end
          OP_DELETE: begin
            if (sts_i.out_free) begin
              cmd_o.delf       = sts_i.right_nz;
              cmd_o.st_load    = 1'b1;
              cmd_o.st_applied = sts_i.right_nz;
              state_d          = ST_IDLE;
            end
          end
          OP_SUBMIT: begin
            if (sts_i.sub_ok) begin
              cmd_o.sub_start = 1'b1;
              state_d         = ST_SRD;
            end else if (sts_i.out_free) begin
              cmd_o.st_load = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.st_load = 1'b1;
              state_d       = ST_IDLE;
            end
          end
        endcase
      end
      // move: read data is back, write the other stack
      ST_MOVE: begin
        if (sts_i.out_free) begin
          cmd_o.mvl_wr     = (sts_i.op == OP_LEFT);
          cmd_o.mvr_wr     = (sts_i.op != OP_LEFT);
          cmd_o.st_load    = 1'b1;
          cmd_o.st_applied = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      // submit: fetch one character
      ST_SRD: begin
        cmd_o.sub_rd = 1'b1;
        state_d      = ST_SLD;
      end
      // submit: hand the character to the output register
      ST_SLD: begin
        if (sts_i.out_free) begin
          cmd_o.sub_load = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_SRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/gble_dp.sv
// datapath of the gap buffer line editor: both stacks, lengths,
// submit index and result register; depends on gble_pkg
`default_nettype none

module gble_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gble_pkg::cmd_t cmd_i,
  input  logic [2:0]    op_i,
  input  logic [7:0]    ch_i,
  input  logic [6:0]    cap_i,
  input  logic          out_ready_i,
  output gble_pkg::sts_t sts_o,
  output logic          out_valid_o,
  output logic          out_kind_o,
  output logic [7:0]    out_char_o,
  output logic          out_last_o,
  output logic          out_applied_o,
  output logic [6:0]    out_left_o,
  output logic [6:0]    out_right_o
);
  import gble_pkg::*;

  logic [2:0]        op_q;
  logic [7:0]        ch_q;
  logic [LEN_W-1:0]  left_len_q, left_len_d;
  logic [LEN_W-1:0]  right_len_q, right_len_d;
  logic [ADDR_W-1:0] idx_q;
  logic              src_right_q;

  logic [7:0] left_mem  [MAX_CHARS];
  logic [7:0] right_mem [MAX_CHARS];
  logic [7:0] lrd_q, rrd_q;

  logic              out_valid_q;
  logic              out_kind_q, out_last_q, out_applied_q;
  logic [7:0]        out_char_q;
  logic [6:0]        out_left_q, out_right_q;

  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  total_m1;
  logic [TOT_W-1:0]  sub_raddr;
  logic [LEN_W-1:0]  left_m1, right_m1;
  logic              idx_in_left;
  logic              out_free;

  // line totals and derived addresses
  assign total       = {1'b0, left_len_q} + {1'b0, right_len_q};
  assign total_m1    = total - TOT_W'(1);
  assign sub_raddr   = total_m1 - {{(TOT_W-ADDR_W){1'b0}}, idx_q};
  assign left_m1     = left_len_q - LEN_W'(1);
  assign right_m1    = right_len_q - LEN_W'(1);
  assign idx_in_left = ({{(LEN_W-ADDR_W){1'b0}}, idx_q} < left_len_q);
  assign out_free    = !out_valid_q || out_ready_i;

  // status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.ins_ok     = (total < {1'b0, cap_i}) && (ch_q >= CHAR_MIN) &&
                       (ch_q <= CHAR_MAX) && (left_len_q < MAX_LEN);
    sts_o.left_nz    = (left_len_q != '0);
    sts_o.right_nz   = (right_len_q != '0);
    sts_o.left_room  = (left_len_q < MAX_LEN);
    sts_o.right_room = (right_len_q < MAX_LEN);
    sts_o.sub_ok     = (total != '0) && (total <= TOT_W'(MAX_CHARS));
    sts_o.out_free   = out_free;
    sts_o.idx_last   = ({{(TOT_W-ADDR_W){1'b0}}, idx_q} == total_m1);
    sts_o.total      = total;
  end

  // accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      op_q <= op_i;
      ch_q <= ch_i;
    end
  end

  // stack lengths
  always_comb begin
    left_len_d  = left_len_q;
    right_len_d = right_len_q;
    if (cmd_i.ins_wr || cmd_i.mvr_wr) begin
      left_len_d = left_len_q + LEN_W'(1);
    end
    if (cmd_i.mvl_wr || cmd_i.bksp) begin
      left_len_d = left_m1;
    end
    if (cmd_i.mvl_wr) begin
      right_len_d = right_len_q + LEN_W'(1);
    end
    if (cmd_i.mvr_wr || cmd_i.delf) begin
      right_len_d = right_m1;
    end
    if (cmd_i.clear) begin
      left_len_d  = '0;
      right_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_len_q  <= '0;
      right_len_q <= '0;
    end else begin
      left_len_q  <= left_len_d;
      right_len_q <= right_len_d;
    end
  end

  // submit index and source select
  always_ff @(posedge clk_i) begin
    if (cmd_i.sub_start) begin
      idx_q <= '0;
    end else if (cmd_i.sub_load) begin
      idx_q <= idx_q + ADDR_W'(1);
    end
    if (cmd_i.sub_rd) begin
      src_right_q <= !idx_in_left;
    end
  end

  // left stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr || cmd_i.mvr_wr) begin
      left_mem[left_len_q[ADDR_W-1:0]] <= cmd_i.ins_wr ? ch_q : rrd_q;
    end
    if (cmd_i.mvl_rd) begin
      lrd_q <= left_mem[left_m1[ADDR_W-1:0]];
    end else if (cmd_i.sub_rd && idx_in_left) begin
      lrd_q <= left_mem[idx_q];
    end
  end

  // right stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.mvl_wr) begin
      right_mem[right_len_q[ADDR_W-1:0]] <= lrd_q;
    end
    if (cmd_i.mvr_rd) begin
      rrd_q <= right_mem[right_m1[ADDR_W-1:0]];
    end else if (cmd_i.sub_rd && !idx_in_left) begin
      rrd_q <= right_mem[sub_raddr[ADDR_W-1:0]];
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.st_load || cmd_i.sub_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.st_load) begin
      out_kind_q    <= 1'b0;
      out_char_q    <= '0;
      out_last_q    <= 1'b1;
      out_applied_q <= cmd_i.st_applied;
      out_left_q    <= left_len_d;
      out_right_q   <= right_len_d;
    end else if (cmd_i.sub_load) begin
      out_kind_q    <= 1'b1;
      out_char_q    <= src_right_q ? rrd_q : lrd_q;
      out_last_q    <= sts_o.idx_last;
      out_applied_q <= 1'b1;
      out_left_q    <= '0;
      out_right_q   <= '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_char_o    = out_char_q;
  assign out_last_o    = out_last_q;
  assign out_applied_o = out_applied_q;
  assign out_left_o    = out_left_q;
  assign out_right_o   = out_right_q;

endmodule

`default_nettype wire

### rtl/gap_buffer_line_editor_top.sv
// edits, moves and refused ops end with one status load into the result register; moves first read
// the source stack; a new item is taken only once the state machine is back in idle
// submit of n characters: one memory read and one result load per character
// reset: asynchronous active low; line empty, line limit 64, result register empty
// the character stores are not cleared; only written entries are ever read
`default_nettype none

`include "gap_buffer_line_editor_top_macros.svh"

module gap_buffer_line_editor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] char_out, [8] applied, [15:9] left_count,
                                      // [22:16] right_count, [23] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gble_pkg::*;

  logic [6:0] max_len_q;
  logic [6:0] cap;
  cmd_t       cmd;
  sts_t       sts;
  logic       out_applied;
  logic [6:0] out_left, out_right;
  logic [7:0] out_char;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAXLEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LINE_LIMIT)) begin
      max_len_q <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == REG_LINE_LIMIT) ? {25'b0, max_len_q} : 32'b0;

  // capacity saturates at the store depth
  assign cap = (max_len_q > MAX_LEN) ? MAX_LEN : max_len_q;

  gble_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gble_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (s_axis_tuser),
    .ch_i          (s_axis_tdata),
    .cap_i         (cap),
    .out_ready_i   (m_axis_tready),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_kind_o    (m_axis_tuser),
    .out_char_o    (out_char),
    .out_last_o    (m_axis_tlast),
    .out_applied_o (out_applied),
    .out_left_o    (out_left),
    .out_right_o   (out_right)
  );

  // result packing
  assign m_axis_tdata = {1'b0, out_right, out_left, out_applied, out_char};

  // line never grows past the store depth
  `GBLE_ASSERT_CLK(a_total_bound, clk_i, rst_ni, sts.total <= TOT_W'(MAX_CHARS), "line too long")
  // one item at a time: no accept right after an accept
  `GBLE_ASSERT_CLK(a_one_item, clk_i, rst_ni,
                   (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "back to back accept")
  // status and character loads never collide
  `GBLE_ASSERT_NEVER(a_load_clash, clk_i, rst_ni, cmd.st_load && cmd.sub_load,
                     "two result loads at once")

endmodule

`default_nettype wire
